// File: src/dwc_pkg.sv
// Package for the depthwise 3x3 row-stream convolution block.
// Holds the stream layout constants, the command codes and fixed sizes.
// No dependencies; imported by every module of the block except dwc_ram.
package dwc_pkg;

    localparam int SLOT_BITS  = 16;   // every lane and tap occupies one 16-bit slot
    localparam int KSIZE      = 3;
    localparam int NTAPS      = 9;
    localparam int OUT_SLOTS  = 14;   // output lane slots on the result stream
    localparam int CH_BITS    = 4;
    localparam int ROW_BITS   = 16;
    localparam int STRIDE_BITS = 2;

    // Input request layout on s_tdata, lowest bit first.
    localparam int S_CH_LSB    = 0;
    localparam int S_ROW_LSB   = S_CH_LSB + CH_BITS;
    localparam int S_LANE_LSB  = S_ROW_LSB + ROW_BITS;
    localparam int S_TAP_LSB   = S_LANE_LSB + 4 * 64;
    localparam int S_USED_BITS = S_TAP_LSB + NTAPS * SLOT_BITS;
    localparam int S_TDATA_W   = ((S_USED_BITS + 7) / 8) * 8;

    // Result layout on m_tdata, lowest bit first.
    localparam int M_CH_LSB    = 0;
    localparam int M_ROW_LSB   = M_CH_LSB + CH_BITS;
    localparam int M_LANE_LSB  = M_ROW_LSB + ROW_BITS;
    localparam int M_USED_BITS = M_LANE_LSB + OUT_SLOTS * SLOT_BITS;
    localparam int M_TDATA_W   = ((M_USED_BITS + 7) / 8) * 8;

    typedef enum logic {
        CMD_WEIGHTS = 1'b0,
        CMD_ROW     = 1'b1
    } dwc_cmd_t;

endpackage

// File: src/dwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the per-channel tap rows and partial-sum rows; no dependencies.
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dwc_row_mac.sv
// Combinational lane array: three 3-tap dot products per output lane and
// the partial-sum update. Depends on dwc_pkg.
module dwc_row_mac
    import dwc_pkg::*;
#(
    parameter int IN_LANES  = 16,
    parameter int OUT_LANES = 14,
    parameter int ELEM_BITS = 16
) (
    input  logic                           stride2,
    input  logic [IN_LANES*ELEM_BITS-1:0]  lanes,
    input  logic [NTAPS*ELEM_BITS-1:0]     taps,
    input  logic [OUT_LANES*ELEM_BITS-1:0] part_top,
    input  logic [OUT_LANES*ELEM_BITS-1:0] part_mid,
    output logic [OUT_LANES*ELEM_BITS-1:0] result,
    output logic [OUT_LANES*ELEM_BITS-1:0] new_top,
    output logic [OUT_LANES*ELEM_BITS-1:0] new_mid
);

    // Highest lane any output lane can touch is 2*(OUT_LANES-1)+2.
    localparam int LANE_EXT = 2 * OUT_LANES + 1;

    logic [ELEM_BITS-1:0] ext [LANE_EXT];
    logic [ELEM_BITS-1:0] kern [NTAPS];

    // Lanes past the input row read as zero.
    for (genvar i = 0; i < LANE_EXT; i++) begin : g_ext
        if (i < IN_LANES) begin : g_in
            assign ext[i] = lanes[i*ELEM_BITS +: ELEM_BITS];
        end else begin : g_zero
            assign ext[i] = '0;
        end
    end

    for (genvar k = 0; k < NTAPS; k++) begin : g_kern
        assign kern[k] = taps[k*ELEM_BITS +: ELEM_BITS];
    end

    for (genvar w = 0; w < OUT_LANES; w++) begin : g_lane
        logic [ELEM_BITS-1:0] dot0;
        logic [ELEM_BITS-1:0] dot1;
        logic [ELEM_BITS-1:0] dot2;

        always_comb begin
            logic [ELEM_BITS-1:0] x [KSIZE];
            logic [ELEM_BITS-1:0] acc [KSIZE];
            for (int t = 0; t < KSIZE; t++) begin
                x[t] = stride2 ? ext[2*w+t] : ext[w+t];
            end
            for (int r = 0; r < KSIZE; r++) begin
                acc[r] = '0;
                for (int t = 0; t < KSIZE; t++) begin
                    acc[r] = acc[r] + x[t] * kern[r*KSIZE+t];
                end
            end
            dot0 = acc[0];
            dot1 = acc[1];
            dot2 = acc[2];
        end

        assign new_top[w*ELEM_BITS +: ELEM_BITS] = dot0;
        assign new_mid[w*ELEM_BITS +: ELEM_BITS] =
            dot1 + part_top[w*ELEM_BITS +: ELEM_BITS];
        assign result[w*ELEM_BITS +: ELEM_BITS] =
            dot2 + part_mid[w*ELEM_BITS +: ELEM_BITS];
    end

endmodule

// File: src/depthwise_conv3x3_row_stream.sv
// Depthwise 3x3 convolution over streamed rows, one channel tile.
// A row request accepted into the stage register writes its result into the result register
// (m_tvalid) as it leaves the stage. Throughput: one request per cycle, any channel mix, while
// no held result stalls the stage. The rate is set by the single read and write port of each row RAM.
// Reset (aresetn low, synchronous) sets the stride to 1 and clears the row
// valid bits, so taps and partial sums read as zero until written.
module depthwise_conv3x3_row_stream
    import dwc_pkg::*;
#(
    parameter int IN_LANES      = 16,
    parameter int OUT_LANES     = 14,
    parameter int TILE_CHANNELS = 16,
    parameter int ELEM_BITS     = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [STRIDE_BITS-1:0] cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // channel, row_index, row_word0..3, tap_word0, tap_word1, tap_last, zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_channel, out_row, out_word0..2, out_word3, zero fill
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int CH_AW = (TILE_CHANNELS > 1) ? $clog2(TILE_CHANNELS) : 1;
    localparam int W_W   = NTAPS * ELEM_BITS;
    localparam int P_W   = OUT_LANES * ELEM_BITS;
    localparam int L_W   = IN_LANES * ELEM_BITS;

    logic [STRIDE_BITS-1:0]   conv_stride_reg;

    logic                     st_valid_reg, st_valid_next;
    logic [CH_AW-1:0]         st_chan_reg;
    logic [ROW_BITS-1:0]      st_row_reg;
    logic [L_W-1:0]           st_lanes_reg;
    logic                     wvalid_hit_reg;
    logic                     pvalid_hit_reg;
    logic                     byp_hit_reg;
    logic [2*P_W-1:0]         byp_data_reg;

    logic [TILE_CHANNELS-1:0] wvalid_reg, wvalid_next;
    logic [TILE_CHANNELS-1:0] pvalid_reg, pvalid_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [CH_BITS-1:0]       m_chan_reg;
    logic [ROW_BITS-1:0]      m_row_reg;
    logic [OUT_SLOTS*SLOT_BITS-1:0] m_lanes_reg;

    logic [CH_BITS-1:0]       in_chan;
    logic [CH_AW-1:0]         in_addr;
    logic                     in_chan_ok;
    logic                     accept;
    logic                     acc_w;
    logic                     acc_r;
    logic [W_W-1:0]           in_taps;
    logic [L_W-1:0]           in_lanes;

    logic                     st_emit;
    logic                     st_adv;
    logic [W_W-1:0]           w_rdata;
    logic [2*P_W-1:0]         p_rdata;
    logic [W_W-1:0]           cur_taps;
    logic [2*P_W-1:0]         cur_part;
    logic [P_W-1:0]           mac_result;
    logic [P_W-1:0]           mac_top;
    logic [P_W-1:0]           mac_mid;
    logic [OUT_SLOTS*SLOT_BITS-1:0] out_lanes;

    // Request decode.
    assign in_chan    = s_tdata[S_CH_LSB +: CH_BITS];
    assign in_addr    = in_chan[CH_AW-1:0];
    assign in_chan_ok = {1'b0, in_chan} < (CH_BITS+1)'(TILE_CHANNELS);
    assign accept     = s_tvalid && s_tready;
    assign acc_w      = accept && (s_tuser == CMD_WEIGHTS) && in_chan_ok;
    assign acc_r      = accept && (s_tuser == CMD_ROW) && in_chan_ok;

    for (genvar t = 0; t < NTAPS; t++) begin : g_taps
        assign in_taps[t*ELEM_BITS +: ELEM_BITS] =
            s_tdata[S_TAP_LSB + t*SLOT_BITS +: ELEM_BITS];
    end

    for (genvar i = 0; i < IN_LANES; i++) begin : g_lanes
        assign in_lanes[i*ELEM_BITS +: ELEM_BITS] =
            s_tdata[S_LANE_LSB + i*SLOT_BITS +: ELEM_BITS];
    end

    // A row that completes no output need not wait for the result register.
    assign st_emit  = (|st_row_reg[ROW_BITS-1:1]) &&
                      (!conv_stride_reg[1] || !st_row_reg[0]);
    assign st_adv   = st_valid_reg && (!st_emit || !m_tvalid_reg || m_tready);
    assign s_tready = !st_valid_reg || st_adv;

    // Taps are written at the weight request's own edge, so a later row
    // request on the same channel always reads them from the RAM.
    dwc_ram #(
        .WIDTH (W_W),
        .DEPTH (TILE_CHANNELS),
        .AW    (CH_AW)
    ) u_wram (
        .aclk  (aclk),
        .we    (acc_w),
        .waddr (in_addr),
        .wdata (in_taps),
        .re    (acc_r),
        .raddr (in_addr),
        .rdata (w_rdata)
    );

    // Partial rows: mid in the upper half, top in the lower half.
    dwc_ram #(
        .WIDTH (2 * P_W),
        .DEPTH (TILE_CHANNELS),
        .AW    (CH_AW)
    ) u_pram (
        .aclk  (aclk),
        .we    (st_adv),
        .waddr (st_chan_reg),
        .wdata ({mac_mid, mac_top}),
        .re    (acc_r),
        .raddr (in_addr),
        .rdata (p_rdata)
    );

    // When the row leaving the stage writes the channel that the incoming
    // row reads at the same edge, the fresh sums are forwarded.
    assign cur_taps = wvalid_hit_reg ? w_rdata : '0;
    assign cur_part = byp_hit_reg    ? byp_data_reg :
                      pvalid_hit_reg ? p_rdata : '0;

    dwc_row_mac #(
        .IN_LANES  (IN_LANES),
        .OUT_LANES (OUT_LANES),
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .stride2  (conv_stride_reg[1]),
        .lanes    (st_lanes_reg),
        .taps     (cur_taps),
        .part_top (cur_part[P_W-1:0]),
        .part_mid (cur_part[2*P_W-1:P_W]),
        .result   (mac_result),
        .new_top  (mac_top),
        .new_mid  (mac_mid)
    );

    for (genvar w = 0; w < OUT_SLOTS; w++) begin : g_out
        if (w < OUT_LANES) begin : g_used
            assign out_lanes[w*SLOT_BITS +: SLOT_BITS] =
                SLOT_BITS'($signed(mac_result[w*ELEM_BITS +: ELEM_BITS]));
        end else begin : g_unused
            assign out_lanes[w*SLOT_BITS +: SLOT_BITS] = '0;
        end
    end

    // Control next-state.
    always_comb begin
        st_valid_next = st_valid_reg;
        if (acc_r) begin
            st_valid_next = 1'b1;
        end else if (st_adv) begin
            st_valid_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (st_adv && st_emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        wvalid_next = wvalid_reg;
        if (acc_w) begin
            wvalid_next[in_addr] = 1'b1;
        end

        pvalid_next = pvalid_reg;
        if (st_adv) begin
            pvalid_next[st_chan_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_stride_reg <= STRIDE_BITS'(1);
            st_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            wvalid_reg      <= '0;
            pvalid_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                conv_stride_reg <= cfg_wr_data;
            end
            st_valid_reg <= st_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            wvalid_reg   <= wvalid_next;
            pvalid_reg   <= pvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (acc_r) begin
            st_chan_reg    <= in_addr;
            st_row_reg     <= s_tdata[S_ROW_LSB +: ROW_BITS];
            st_lanes_reg   <= in_lanes;
            wvalid_hit_reg <= wvalid_reg[in_addr];
            pvalid_hit_reg <= pvalid_reg[in_addr];
            byp_hit_reg    <= st_adv && (st_chan_reg == in_addr);
            byp_data_reg   <= {mac_mid, mac_top};
        end
        if (st_adv && st_emit) begin
            m_chan_reg  <= CH_BITS'(st_chan_reg);
            m_row_reg   <= st_row_reg;
            m_lanes_reg <= out_lanes;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-M_USED_BITS)'(0), m_lanes_reg, m_row_reg, m_chan_reg};

endmodule

// File: src/dwc_checker.sv
// Port-level checks for the depthwise 3x3 row-stream block, bound to the
// top level below. Depends on dwc_pkg and depthwise_conv3x3_row_stream.
module dwc_checker
    import dwc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result waiting on the consumer is held unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only rows above 1 complete an output row.
    a_row_above_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_ROW_LSB+ROW_BITS-1:M_ROW_LSB+1] != '0))
        else $error("result for row 0 or 1");

    // Fill bits above the packed fields stay zero.
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_USED_BITS] == '0))
        else $error("nonzero fill bits in result");

endmodule

bind depthwise_conv3x3_row_stream dwc_checker u_dwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_depthwise_conv3x3_row_stream.sv
// Self-checking testbench for depthwise_conv3x3_row_stream: streams tap loads and input rows,
// predicts every output row, and checks each result field against the expected row.
// Depends on dwc_pkg and the block itself; needs no other file.
`timescale 1ns / 1ps

module tb_depthwise_conv3x3_row_stream;
    import dwc_pkg::*;

    localparam int IN_LANES      = 16;
    localparam int OUT_LANES     = 14;
    localparam int TILE_CHANNELS = 16;
    localparam int LANE_BITS     = IN_LANES * SLOT_BITS;
    localparam int TAP_BITS      = NTAPS * SLOT_BITS;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        dwc_cmd_t               cmd;
        logic [S_TDATA_W-1:0]   data;
    } conv_req_t;

    typedef struct packed {
        logic [CH_BITS-1:0]               ch;
        logic [ROW_BITS-1:0]              row;
        logic [OUT_SLOTS*SLOT_BITS-1:0]   lanes;
    } conv_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [STRIDE_BITS-1:0] cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    depthwise_conv3x3_row_stream dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the block state, updated as requests are accepted.
    logic [1:0]            stride_cfg = 2'd1;
    logic [SLOT_BITS-1:0]  tap_mem [TILE_CHANNELS][NTAPS];
    logic [SLOT_BITS-1:0]  top_sum [TILE_CHANNELS][OUT_LANES];
    logic [SLOT_BITS-1:0]  mid_sum [TILE_CHANNELS][OUT_LANES];

    conv_req_t  pending_q[$];
    conv_out_t  out_row_q[$];
    conv_req_t  next_req;
    conv_out_t  exp_row;

    int n_queued = 0;
    int n_accepted = 0;
    int n_tap_loads = 0;
    int n_rows_in = 0;
    int n_rows_checked = 0;
    int n_errors = 0;
    int cycle_count = 0;
    logic stall_kick = 1'b0;

    initial begin
        for (int c = 0; c < TILE_CHANNELS; c++) begin
            for (int t = 0; t < NTAPS; t++) tap_mem[c][t] = '0;
            for (int w = 0; w < OUT_LANES; w++) begin
                top_sum[c][w] = '0;
                mid_sum[c][w] = '0;
            end
        end
    end

    // Updates the shadow state for one accepted request and queues the output row it finishes.
    function automatic void conv_row_predict(input dwc_cmd_t cmd, input logic [S_TDATA_W-1:0] d);
        logic [CH_BITS-1:0]   ch;
        logic [ROW_BITS-1:0]  row;
        logic [SLOT_BITS-1:0] pix [IN_LANES];
        logic [SLOT_BITS-1:0] dot [KSIZE];
        logic [SLOT_BITS-1:0] x;
        conv_out_t            res;
        int                   step;
        int                   idx;
        ch  = d[S_CH_LSB +: CH_BITS];
        row = d[S_ROW_LSB +: ROW_BITS];
        if (cmd == CMD_WEIGHTS) begin
            for (int t = 0; t < NTAPS; t++) tap_mem[ch][t] = d[S_TAP_LSB + SLOT_BITS*t +: SLOT_BITS];
            return;
        end
        // A stride register of 0 behaves as 1 and 3 behaves as 2.
        step = (stride_cfg == 2'd0) ? 1 : (stride_cfg == 2'd3) ? 2 : int'(stride_cfg);
        for (int i = 0; i < IN_LANES; i++) pix[i] = d[S_LANE_LSB + SLOT_BITS*i +: SLOT_BITS];
        res.ch = ch;
        res.row = row;
        res.lanes = '0;
        for (int w = 0; w < OUT_LANES; w++) begin
            for (int r = 0; r < KSIZE; r++) begin
                dot[r] = '0;
                for (int t = 0; t < KSIZE; t++) begin
                    idx = step * w + t;
                    // Taps that run past the right edge of the row see zero.
                    x = (idx < IN_LANES) ? pix[idx] : '0;
                    dot[r] = dot[r] + x * tap_mem[ch][r*KSIZE + t];
                end
            end
            res.lanes[SLOT_BITS*w +: SLOT_BITS] = dot[2] + mid_sum[ch][w];
            mid_sum[ch][w] = dot[1] + top_sum[ch][w];
            top_sum[ch][w] = dot[0];
        end
        if (row > 1 && (row % step) == 0) out_row_q.push_back(res);
    endfunction

    function automatic logic [LANE_BITS-1:0] rand_slots(input int style);
        logic [LANE_BITS-1:0] v;
        logic [SLOT_BITS-1:0] pick [5];
        pick = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001};
        for (int i = 0; i < IN_LANES; i++) begin
            case (style)
                0: v[SLOT_BITS*i +: SLOT_BITS] = 16'($urandom);
                1: v[SLOT_BITS*i +: SLOT_BITS] = 16'($urandom_range(0, 15) - 8);
                default: v[SLOT_BITS*i +: SLOT_BITS] = pick[$urandom_range(0, 4)];
            endcase
        end
        return v;
    endfunction

    task automatic queue_item(input dwc_cmd_t cmd, input logic [CH_BITS-1:0] ch,
                              input logic [ROW_BITS-1:0] row,
                              input logic [LANE_BITS-1:0] pix, input logic [TAP_BITS-1:0] taps);
        conv_req_t req;
        req.cmd = cmd;
        req.data = '0;
        req.data[S_CH_LSB +: CH_BITS] = ch;
        req.data[S_ROW_LSB +: ROW_BITS] = row;
        req.data[S_LANE_LSB +: LANE_BITS] = pix;
        req.data[S_TAP_LSB +: TAP_BITS] = taps;
        pending_q.push_back(req);
        n_queued++;
    endtask

    // The block may still be busy with a request that yields no row, hence the extra cycles.
    task automatic wait_idle();
        do @(posedge aclk);
        while (n_accepted != n_queued || out_row_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stride(input logic [STRIDE_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] expv, input logic [63:0] actv);
        if (expv !== actv) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expv, actv);
        end
    endtask

    // Sender: bursts of random length separated by random gaps, some of them zero.
    int burst_left = 0;
    int gap_left = 0;
    int gap_pick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                next_req = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_req.data;
                s_tuser <= next_req.cmd;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_pick = $urandom_range(0, 9);
                    gap_left = (gap_pick < 4) ? 0 :
                               (gap_pick < 9) ? $urandom_range(1, 5) : $urandom_range(10, 24);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns; a kick from the sequence forces a long hold.
    logic stall_ack = 1'b0;
    int   hold_cycles = 0;
    int   rx_mode = 0;
    int   mode_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_kick != stall_ack) begin
                stall_ack = stall_kick;
                hold_cycles = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ((cycle_count % 4) == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Input side: track the stride register and predict every accepted request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) stride_cfg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                conv_row_predict(dwc_cmd_t'(s_tuser), s_tdata);
                if (s_tuser == CMD_WEIGHTS) n_tap_loads++;
                else n_rows_in++;
                n_accepted++;
            end
        end
    end

    // Output side: each accepted row is compared with the oldest expected row.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (out_row_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected output row, expected none, got %h", $time, m_tdata);
            end else begin
                exp_row = out_row_q.pop_front();
                check_field("out_channel", 64'(exp_row.ch), 64'(m_tdata[M_CH_LSB +: CH_BITS]));
                check_field("out_row", 64'(exp_row.row), 64'(m_tdata[M_ROW_LSB +: ROW_BITS]));
                check_field("out_word0", exp_row.lanes[0 +: 64], m_tdata[M_LANE_LSB +: 64]);
                check_field("out_word1", exp_row.lanes[64 +: 64], m_tdata[M_LANE_LSB + 64 +: 64]);
                check_field("out_word2", exp_row.lanes[128 +: 64], m_tdata[M_LANE_LSB + 128 +: 64]);
                check_field("out_word3", 64'(exp_row.lanes[192 +: 32]),
                            64'(m_tdata[M_LANE_LSB + 192 +: 32]));
                n_rows_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d output rows still expected",
                     cycle_count, out_row_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : sequence_main
        logic [STRIDE_BITS-1:0] stride_plan [6];
        logic [ROW_BITS-1:0]    row_pos [TILE_CHANNELS];
        logic [SLOT_BITS-1:0]   fill [4];
        logic [CH_BITS-1:0]     ch;
        int                     top_ch;
        int                     strip_len;
        int                     sel;
        stride_plan = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        fill = '{16'h7fff, 16'h8000, 16'hffff, 16'h0000};

        // Directed part at the reset stride: a row before any taps are loaded, taps at the
        // extremes, full-scale rows, rows near the top of the row range, and interleaving.
        queue_item(CMD_ROW, 4'd0, 16'd2, rand_slots(0), TAP_BITS'(rand_slots(0)));
        queue_item(CMD_WEIGHTS, 4'd0, 16'hffff, rand_slots(0), {NTAPS{16'h7fff}});
        queue_item(CMD_WEIGHTS, 4'd1, 16'd0, rand_slots(0), {NTAPS{16'h8000}});
        queue_item(CMD_WEIGHTS, 4'd15, 16'd7, rand_slots(0),
                   {16'h8001, 16'h0003, 16'hfffe, 16'h0002, 16'h0000,
                    16'h7fff, 16'h8000, 16'hffff, 16'h0001});
        for (int r = 0; r < 4; r++) begin
            queue_item(CMD_ROW, 4'd0, 16'(r), {IN_LANES{fill[r]}}, TAP_BITS'(rand_slots(0)));
            queue_item(CMD_ROW, 4'd1, 16'(r), {IN_LANES{fill[3 - r]}}, TAP_BITS'(rand_slots(0)));
            queue_item(CMD_ROW, 4'd15, 16'(65534 + r), rand_slots(r % 3),
                       TAP_BITS'(rand_slots(0)));
        end
        queue_item(CMD_WEIGHTS, 4'd0, 16'd0, rand_slots(0), TAP_BITS'(rand_slots(2)));
        queue_item(CMD_ROW, 4'd0, 16'd4, rand_slots(2), TAP_BITS'(rand_slots(0)));
        queue_item(CMD_ROW, 4'd15, 16'd2, rand_slots(0), TAP_BITS'(rand_slots(0)));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            // Hold the sender until every expected row is back, then change the stride.
            wait_idle();
            write_stride(stride_plan[p]);
            top_ch = (p % 3 == 0) ? 15 : (p % 3 == 1) ? 3 : 0;
            strip_len = $urandom_range(6, 24);
            for (int c = 0; c < TILE_CHANNELS; c++) row_pos[c] = '0;
            for (int k = 0; k < 280; k++) begin
                sel = $urandom_range(0, 99);
                ch = 4'($urandom_range(0, top_ch));
                if (sel < 8) begin
                    queue_item(CMD_WEIGHTS, ch, 16'($urandom), rand_slots(0),
                               TAP_BITS'(rand_slots($urandom_range(0, 2))));
                end else if (sel < 13) begin
                    queue_item(CMD_ROW, 4'($urandom), 16'($urandom), rand_slots(0),
                               TAP_BITS'(rand_slots(0)));
                end else begin
                    queue_item(CMD_ROW, ch, row_pos[ch], rand_slots($urandom_range(0, 2)),
                               TAP_BITS'(rand_slots(0)));
                    row_pos[ch]++;
                    // A new strip usually starts at row 0, now and then just below the wrap.
                    if (row_pos[ch] == 16'(strip_len))
                        row_pos[ch] = ($urandom_range(0, 9) == 0) ? 16'hfffc : 16'h0000;
                end
            end
            if (p == 3) stall_kick <= ~stall_kick;
        end

        wait_idle();
        $display("stimulus: %0d tap loads and %0d input rows over strides 1, 2, 0 and 3",
                 n_tap_loads, n_rows_in);
        $display("checked %0d output rows, %0d mismatches", n_rows_checked, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/dwc_pkg.sv
src/dwc_ram.sv
src/dwc_row_mac.sv
src/depthwise_conv3x3_row_stream.sv
src/dwc_checker.sv
test/tb_depthwise_conv3x3_row_stream.sv
